### src/single_wire_bus_master_defines.svh
`ifndef SINGLE_WIRE_BUS_MASTER_DEFINES_SVH
`define SINGLE_WIRE_BUS_MASTER_DEFINES_SVH
// concurrent check helpers
`define SWBM_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SWBM_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### src/swbm_pkg.sv
package swbm_pkg;
   localparam logic [3:0] OP_TICK    = 4'd0;
   localparam logic [3:0] OP_RESET   = 4'd1;
   localparam logic [3:0] OP_START   = 4'd2;
   localparam logic [3:0] OP_ADDR    = 4'd3;
   localparam logic [3:0] OP_BYTE    = 4'd4;
   localparam logic [3:0] OP_READ    = 4'd5;
   localparam logic [3:0] OP_GETACK  = 4'd6;
   localparam logic [3:0] OP_SENDACK = 4'd7;
   localparam logic [3:0] OP_NACK    = 4'd8;

   localparam logic [2:0] T_BIT   = 3'd0;
   localparam logic [2:0] T_DRR   = 3'd1;
   localparam logic [2:0] T_HTSS  = 3'd2;
   localparam logic [2:0] T_LOW0  = 3'd3;
   localparam logic [2:0] T_LOW1  = 3'd4;
   localparam logic [2:0] T_RD    = 3'd5;
   localparam logic [2:0] T_RESET = 3'd6;
   localparam logic [2:0] T_RRT   = 3'd7;

   localparam logic [6:0] STUCK_LIMIT = 7'd100;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] tx_byte;
      logic       line;
   } item_type;

   function automatic logic [8:0] tim(input logic spd, input logic [2:0] k);
      logic [8:0] v;
      v = 9'd0;
      if (!spd) begin
         case (k)
            T_BIT:   v = 9'd70;
            T_DRR:   v = 9'd7;
            T_HTSS:  v = 9'd500;
            T_LOW0:  v = 9'd60;
            T_LOW1:  v = 9'd6;
            T_RD:    v = 9'd9;
            T_RESET: v = 9'd480;
            default: v = 9'd20;
         endcase
      end else begin
         case (k)
            T_BIT:   v = 9'd15;
            T_DRR:   v = 9'd1;
            T_HTSS:  v = 9'd150;
            T_LOW0:  v = 9'd8;
            T_LOW1:  v = 9'd1;
            T_RD:    v = 9'd1;
            T_RESET: v = 9'd96;
            default: v = 9'd8;
         endcase
      end
      return v;
   endfunction

   function automatic logic tx_bit(input logic [3:0] cmd, input logic [7:0] sh,
                                   input logic [3:0] bi);
      logic b;
      b = sh[3'd7 - bi[2:0]];
      if (cmd == OP_SENDACK) b = 1'b0;
      else if (cmd == OP_NACK) b = 1'b1;
      return b;
   endfunction
endpackage

### src/swbm_req_if.sv
interface swbm_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] operation;
   logic [7:0] tx_byte;
   logic       line_in;
   modport source (output valid, operation, tx_byte, line_in, input ready);
   modport sink (input valid, operation, tx_byte, line_in, output ready);
endinterface

### src/swbm_rsp_if.sv
interface swbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       ack;
   logic [7:0] rx_byte;
   logic       stuck_error;
   modport source (output valid, drive_low, busy_res, done_res, ack, rx_byte, stuck_error,
                   input ready);
   modport sink (input valid, drive_low, busy_res, done_res, ack, rx_byte, stuck_error,
                 output ready);
endinterface

### src/swbm_front.sv
module swbm_front (
   input  logic              clock,
   input  logic              reset,
   swbm_req_if.sink          req_if,
   output swbm_pkg::item_type item_out,
   output logic              item_valid,
   input  logic              item_ready
);
   swbm_pkg::item_type q_ff [2];
   swbm_pkg::item_type cls;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push, pop;

   // unknown codes run as plain ticks
   always_comb begin
      cls.op      = (req_if.operation >= swbm_pkg::OP_RESET &&
                     req_if.operation <= swbm_pkg::OP_NACK) ? req_if.operation
                                                            : swbm_pkg::OP_TICK;
      cls.tx_byte = req_if.tx_byte;
      cls.line    = req_if.line_in;
   end

   assign req_if.ready = (cnt_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign item_valid   = (cnt_ff != 2'd0);
   assign pop          = item_valid && item_ready;
   assign item_out     = q_ff[rd_ff];
   assign cnt_in       = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_in        = pop ? ~rd_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <= cls;
   end
endmodule

### src/swbm_engine.sv
module swbm_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [3:0]         csr_wdata,
   input  swbm_pkg::item_type item_in,
   input  logic               item_valid,
   output logic               item_ready,
   swbm_rsp_if.source         rsp_if
);
   typedef enum logic [14:0] {
      PH_IDLE      = 15'b000000000000001,
      PH_RST_LOW   = 15'b000000000000010,
      PH_RST_REL   = 15'b000000000000100,
      PH_HTSS      = 15'b000000000001000,
      PH_TX_LOW    = 15'b000000000010000,
      PH_TX_REL    = 15'b000000000100000,
      PH_ACK_LOW   = 15'b000000001000000,
      PH_ACK_WAIT  = 15'b000000010000000,
      PH_ACK_SAMP  = 15'b000000100000000,
      PH_ACK_REST  = 15'b000001000000000,
      PH_RD_LOW    = 15'b000010000000000,
      PH_RD_WAIT   = 15'b000100000000000,
      PH_RD_POLL   = 15'b001000000000000,
      PH_RD_RRT    = 15'b010000000000000,
      PH_RD_STUCK  = 15'b100000000000000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] cmd_ff, cmd_in;
   logic [8:0] tick_ff, tick_in;
   logic [3:0] bi_ff, bi_in;
   logic [7:0] sh_ff, sh_in;
   logic       sb_ff, sb_in, af_ff, af_in;
   logic [6:0] sc_ff, sc_in;
   logic       spd_ff, spd_in;
   logic [3:0] lrt_ff, lrt_in;
   logic       ov_ff, ov_in;
   logic       drv_in, busy_in, done_in, ack_in, stk_in;
   logic [7:0] rx_in;
   logic       drv_ff, busy_ff, done_ff, ack_ff, stk_ff;
   logic [7:0] rx_ff;
   logic       take, z, fin, txlow;
   logic signed [10:0] rem;

   assign item_ready = !ov_ff || rsp_if.ready;
   assign take       = item_valid && item_ready;

   always_comb begin
      phase_in = phase_ff; cmd_in = cmd_ff; tick_in = tick_ff; bi_in = bi_ff;
      sh_in = sh_ff; sb_in = sb_ff; af_in = af_ff; sc_in = sc_ff;
      drv_in = 1'b0; done_in = 1'b0; ack_in = 1'b0; rx_in = 8'd0; stk_in = 1'b0;
      fin = 1'b0; txlow = 1'b0; z = 1'b0;
      rem = 11'sd0;
      if (phase_in == PH_IDLE && item_in.op != swbm_pkg::OP_TICK) begin
         cmd_in = item_in.op; af_in = 1'b0; bi_in = 4'd0; sc_in = 7'd0;
         case (item_in.op)
            swbm_pkg::OP_RESET: begin
               phase_in = PH_RST_LOW; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RESET);
            end
            swbm_pkg::OP_START: begin
               phase_in = PH_HTSS; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_HTSS);
            end
            swbm_pkg::OP_ADDR: begin
               sh_in = item_in.tx_byte;
               phase_in = PH_HTSS; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_HTSS);
            end
            swbm_pkg::OP_BYTE: begin
               sh_in = item_in.tx_byte; txlow = 1'b1;
            end
            swbm_pkg::OP_READ: begin
               sh_in = 8'd0;
               phase_in = PH_RD_LOW; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RD);
            end
            swbm_pkg::OP_GETACK: begin
               phase_in = PH_ACK_LOW; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_DRR);
            end
            default: txlow = 1'b1;
         endcase
         if (txlow) begin
            sb_in = swbm_pkg::tx_bit(cmd_in, sh_in, bi_in);
            phase_in = PH_TX_LOW;
            tick_in = swbm_pkg::tim(spd_ff, sb_in ? swbm_pkg::T_LOW1 : swbm_pkg::T_LOW0);
         end
         txlow = 1'b0;
      end
      busy_in = (phase_in != PH_IDLE);
      if (tick_in != 9'd0) tick_in = tick_in - 9'd1;
      z = (tick_in == 9'd0);
      case (phase_in)
         PH_IDLE: ;
         PH_RST_LOW: begin
            drv_in = 1'b1;
            if (z) begin
               phase_in = PH_RST_REL; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RRT);
            end
         end
         PH_RST_REL: if (z) begin
            phase_in = PH_ACK_LOW; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_DRR);
         end
         PH_HTSS: if (z) begin
            if (cmd_in == swbm_pkg::OP_START) fin = 1'b1;
            else begin
               bi_in = 4'd0; txlow = 1'b1;
            end
         end
         PH_TX_LOW: begin
            drv_in = 1'b1;
            if (z) begin
               phase_in = PH_TX_REL;
               tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_BIT) -
                  swbm_pkg::tim(spd_ff, sb_in ? swbm_pkg::T_LOW1 : swbm_pkg::T_LOW0);
            end
         end
         PH_TX_REL: if (z) begin
            if (cmd_in == swbm_pkg::OP_SENDACK || cmd_in == swbm_pkg::OP_NACK) fin = 1'b1;
            else begin
               bi_in = bi_in + 4'd1;
               if (bi_in >= 4'd8) begin
                  if (cmd_in == swbm_pkg::OP_ADDR) begin
                     phase_in = PH_ACK_LOW;
                     tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_DRR);
                  end else fin = 1'b1;
               end else txlow = 1'b1;
            end
         end
         PH_ACK_LOW: begin
            drv_in = 1'b1;
            if (z) begin
               if (lrt_ff == 4'd0) begin
                  phase_in = PH_ACK_SAMP; tick_in = 9'd1;
               end else begin
                  phase_in = PH_ACK_WAIT; tick_in = {5'd0, lrt_ff};
               end
            end
         end
         PH_ACK_WAIT: if (z) begin
            phase_in = PH_ACK_SAMP; tick_in = 9'd1;
         end
         PH_ACK_SAMP: begin
            rem = $signed({2'b00, swbm_pkg::tim(spd_ff, swbm_pkg::T_BIT)}) -
                  $signed({2'b00, swbm_pkg::tim(spd_ff, swbm_pkg::T_DRR)}) -
                  $signed({7'd0, lrt_ff}) - 11'sd1;
            af_in = !item_in.line;
            if (rem > 11'sd0) begin
               phase_in = PH_ACK_REST; tick_in = rem[8:0];
            end else fin = 1'b1;
         end
         PH_ACK_REST: if (z) fin = 1'b1;
         PH_RD_LOW: begin
            drv_in = 1'b1;
            if (z) begin
               if (lrt_ff == 4'd0) begin
                  phase_in = PH_RD_POLL; tick_in = 9'd1;
               end else begin
                  phase_in = PH_RD_WAIT; tick_in = {5'd0, lrt_ff};
               end
            end
         end
         PH_RD_WAIT: if (z) begin
            phase_in = PH_RD_POLL; tick_in = 9'd1;
         end
         PH_RD_POLL: begin
            if (sc_in == 7'd0) sb_in = item_in.line;
            if (item_in.line) begin
               sh_in[3'd7 - bi_in[2:0]] = sh_in[3'd7 - bi_in[2:0]] | sb_in;
               phase_in = PH_RD_RRT; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RRT);
            end else begin
               sc_in = sc_in + 7'd1;
               if (sc_in >= swbm_pkg::STUCK_LIMIT) begin
                  phase_in = PH_RD_STUCK; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RRT);
               end
            end
         end
         PH_RD_RRT: if (z) begin
            bi_in = bi_in + 4'd1;
            if (bi_in >= 4'd8) fin = 1'b1;
            else begin
               sc_in = 7'd0;
               phase_in = PH_RD_LOW; tick_in = swbm_pkg::tim(spd_ff, swbm_pkg::T_RD);
            end
         end
         PH_RD_STUCK: if (z) begin
            fin = 1'b1; stk_in = 1'b1;
         end
         default: fin = 1'b1;
      endcase
      if (txlow) begin
         sb_in = swbm_pkg::tx_bit(cmd_in, sh_in, bi_in);
         phase_in = PH_TX_LOW;
         tick_in = swbm_pkg::tim(spd_ff, sb_in ? swbm_pkg::T_LOW1 : swbm_pkg::T_LOW0);
      end
      if (fin) begin
         done_in = 1'b1;
         if (cmd_in == swbm_pkg::OP_RESET || cmd_in == swbm_pkg::OP_ADDR ||
             cmd_in == swbm_pkg::OP_GETACK) ack_in = af_in;
         if (cmd_in == swbm_pkg::OP_READ) rx_in = sh_in;
         else stk_in = 1'b0;
         phase_in = PH_IDLE; tick_in = 9'd0;
      end
   end

   assign ov_in  = take ? 1'b1 : (rsp_if.ready ? 1'b0 : ov_ff);
   assign spd_in = (csr_we && csr_index == 1'b0) ? csr_wdata[0] : spd_ff;
   assign lrt_in = (csr_we && csr_index == 1'b1) ? csr_wdata : lrt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; cmd_ff <= 4'd0; tick_ff <= 9'd0; bi_ff <= 4'd0;
         sh_ff <= 8'd0; sb_ff <= 1'b0; af_ff <= 1'b0; sc_ff <= 7'd0;
         spd_ff <= 1'b1; lrt_ff <= 4'd2; ov_ff <= 1'b0;
      end else begin
         spd_ff <= spd_in; lrt_ff <= lrt_in; ov_ff <= ov_in;
         if (take) begin
            phase_ff <= phase_in; cmd_ff <= cmd_in; tick_ff <= tick_in; bi_ff <= bi_in;
            sh_ff <= sh_in; sb_ff <= sb_in; af_ff <= af_in; sc_ff <= sc_in;
         end
      end
      if (take) begin
         drv_ff <= drv_in; busy_ff <= busy_in; done_ff <= done_in;
         ack_ff <= ack_in; rx_ff <= rx_in; stk_ff <= stk_in;
      end
   end

   assign rsp_if.valid       = ov_ff;
   assign rsp_if.drive_low   = drv_ff;
   assign rsp_if.busy_res    = busy_ff;
   assign rsp_if.done_res    = done_ff;
   assign rsp_if.ack         = ack_ff;
   assign rsp_if.rx_byte     = rx_ff;
   assign rsp_if.stuck_error = stk_ff;
endmodule

### src/single_wire_bus_master.sv
// channel   dir  payload                                          handshake
// req_if    in   operation, tx_byte, line_in                       valid/ready
// rsp_if    out  drive_low, busy_res, done_res, ack, rx_byte,      valid/ready
//                stuck_error
// csr       in   csr_we, csr_index, csr_wdata                      write only
// one tick transfer in and one result transfer out per cycle, sustained while rsp_if is ready
// a tick is registered in the queue and then in the engine result registers before it is offered
// at full rate the input takes one more transfer after the output stalls, then waits
// reset is synchronous; it empties the queue, idles the sequencer and sets timing to fast, return 2
`include "single_wire_bus_master_defines.svh"
module single_wire_bus_master (
   input  logic      clock,
   input  logic      reset,
   swbm_req_if.sink  req_if,
   swbm_rsp_if.source rsp_if,
   input  logic      csr_we,
   input  logic      csr_index,
   input  logic [3:0] csr_wdata
);
   swbm_pkg::item_type item;
   logic item_valid, item_ready;

   swbm_front u_front (
      .clock(clock), .reset(reset), .req_if(req_if),
      .item_out(item), .item_valid(item_valid), .item_ready(item_ready)
   );

   swbm_engine u_engine (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .item_in(item), .item_valid(item_valid),
      .item_ready(item_ready), .rsp_if(rsp_if)
   );

   `SWBM_ASSERT_IMP(a_done_busy, clock, reset, rsp_if.valid && rsp_if.done_res, rsp_if.busy_res, "done without busy")
   `SWBM_ASSERT_IMP(a_ack_done, clock, reset, rsp_if.valid && (rsp_if.ack || rsp_if.stuck_error), rsp_if.done_res, "ack or stuck outside done")
   `SWBM_ASSERT_IMP(a_drive_busy, clock, reset, rsp_if.valid && rsp_if.drive_low, rsp_if.busy_res && !rsp_if.done_res, "drive while idle or on done")
endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

import swbm_pkg::*;

typedef enum logic [4:0] {
   SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_REL, SEQ_HTSS, SEQ_TX_LOW, SEQ_TX_REL,
   SEQ_ACK_LOW, SEQ_ACK_WAIT, SEQ_ACK_SAMPLE, SEQ_ACK_REST, SEQ_RD_LOW,
   SEQ_RD_WAIT, SEQ_RD_POLL, SEQ_RD_RRT, SEQ_RD_STUCK_RRT
} seq_phase_e;

typedef struct packed {
   logic       drive_low;
   logic       busy;
   logic       done;
   logic       ack;
   logic [7:0] rx_byte;
   logic       stuck;
} tick_result_t;

localparam logic CSR_SPEED = 1'b0;
localparam logic CSR_RETURN = 1'b1;

class swbm_scoreboard;
   logic       speed;
   logic [3:0] return_time;
   seq_phase_e phase;
   logic [3:0] cmd;
   logic [8:0] ticks_left;
   logic [3:0] bit_idx;
   logic [7:0] shreg;
   logic       cur_bit;
   logic       ack_seen;
   logic [6:0] low_polls;
   tick_result_t expected_ticks[$];
   int errors;

   function new();
      speed = 1'b1;
      return_time = 4'd2;
      phase = SEQ_IDLE;
      cmd = OP_TICK;
      ticks_left = '0;
      bit_idx = '0;
      shreg = '0;
      cur_bit = 1'b0;
      ack_seen = 1'b0;
      low_polls = '0;
      errors = 0;
   endfunction

   function void write_reg(logic idx, logic [3:0] v);
      if (idx == CSR_SPEED) speed = v[0];
      else return_time = v;
   endfunction

   function logic [8:0] dur(logic [2:0] k);
      logic [8:0] slow [8];
      logic [8:0] fast [8];
      slow = '{9'd70, 9'd7, 9'd500, 9'd60, 9'd6, 9'd9, 9'd480, 9'd20};
      fast = '{9'd15, 9'd1, 9'd150, 9'd8, 9'd1, 9'd1, 9'd96, 9'd8};
      return speed ? fast[k] : slow[k];
   endfunction

   function void go(seq_phase_e p, logic [8:0] n);
      phase = p;
      ticks_left = n;
   endfunction

   function bit expired();
      if (ticks_left > 0) ticks_left--;
      return ticks_left == 0;
   endfunction

   function void start_tx_bit();
      if (cmd == OP_SENDACK) cur_bit = 1'b0;
      else if (cmd == OP_NACK) cur_bit = 1'b1;
      else cur_bit = shreg[7 - bit_idx[2:0]];
      go(SEQ_TX_LOW, dur(cur_bit ? T_LOW1 : T_LOW0));
   endfunction

   function void start_rd_bit();
      low_polls = '0;
      go(SEQ_RD_LOW, dur(T_RD));
   endfunction

   function void note(item_type it);
      tick_result_t r;
      bit fin;
      int rest;
      r = '0;
      fin = 0;
      if (phase == SEQ_IDLE && it.op >= OP_RESET && it.op <= OP_NACK) begin
         cmd = it.op;
         ack_seen = 1'b0;
         bit_idx = '0;
         low_polls = '0;
         case (it.op)
            OP_RESET: go(SEQ_RST_LOW, dur(T_RESET));
            OP_START: go(SEQ_HTSS, dur(T_HTSS));
            OP_ADDR: begin
               shreg = it.tx_byte;
               go(SEQ_HTSS, dur(T_HTSS));
            end
            OP_BYTE: begin
               shreg = it.tx_byte;
               start_tx_bit();
            end
            OP_READ: begin
               shreg = '0;
               start_rd_bit();
            end
            OP_GETACK: go(SEQ_ACK_LOW, dur(T_DRR));
            default: start_tx_bit();
         endcase
      end
      if (phase != SEQ_IDLE) begin
         r.busy = 1'b1;
         case (phase)
            SEQ_RST_LOW: begin
               r.drive_low = 1'b1;
               if (expired()) go(SEQ_RST_REL, dur(T_RRT));
            end
            SEQ_RST_REL: if (expired()) go(SEQ_ACK_LOW, dur(T_DRR));
            SEQ_HTSS: if (expired()) begin
               if (cmd == OP_START) fin = 1;
               else begin
                  bit_idx = '0;
                  start_tx_bit();
               end
            end
            SEQ_TX_LOW: begin
               r.drive_low = 1'b1;
               if (expired())
                  go(SEQ_TX_REL, dur(T_BIT) - dur(cur_bit ? T_LOW1 : T_LOW0));
            end
            SEQ_TX_REL: if (expired()) begin
               if (cmd == OP_SENDACK || cmd == OP_NACK) fin = 1;
               else begin
                  bit_idx++;
                  if (bit_idx >= 8) begin
                     if (cmd == OP_ADDR) go(SEQ_ACK_LOW, dur(T_DRR));
                     else fin = 1;
                  end else start_tx_bit();
               end
            end
            SEQ_ACK_LOW: begin
               r.drive_low = 1'b1;
               if (expired()) begin
                  if (return_time == 0) go(SEQ_ACK_SAMPLE, 9'd1);
                  else go(SEQ_ACK_WAIT, {5'd0, return_time});
               end
            end
            SEQ_ACK_WAIT: if (expired()) go(SEQ_ACK_SAMPLE, 9'd1);
            SEQ_ACK_SAMPLE: begin
               rest = int'(dur(T_BIT)) - int'(dur(T_DRR)) - int'(return_time) - 1;
               ack_seen = !it.line;
               if (rest > 0) go(SEQ_ACK_REST, rest[8:0]);
               else fin = 1;
            end
            SEQ_ACK_REST: if (expired()) fin = 1;
            SEQ_RD_LOW: begin
               r.drive_low = 1'b1;
               if (expired()) begin
                  if (return_time == 0) go(SEQ_RD_POLL, 9'd1);
                  else go(SEQ_RD_WAIT, {5'd0, return_time});
               end
            end
            SEQ_RD_WAIT: if (expired()) go(SEQ_RD_POLL, 9'd1);
            SEQ_RD_POLL: begin
               if (low_polls == 0) cur_bit = it.line;
               if (it.line) begin
                  shreg[7 - bit_idx[2:0]] = shreg[7 - bit_idx[2:0]] | cur_bit;
                  go(SEQ_RD_RRT, dur(T_RRT));
               end else begin
                  low_polls++;
                  if (low_polls >= STUCK_LIMIT) go(SEQ_RD_STUCK_RRT, dur(T_RRT));
               end
            end
            SEQ_RD_RRT: if (expired()) begin
               bit_idx++;
               if (bit_idx >= 8) fin = 1;
               else start_rd_bit();
            end
            SEQ_RD_STUCK_RRT: if (expired()) begin
               fin = 1;
               r.stuck = 1'b1;
            end
            default: fin = 1;
         endcase
         if (fin) begin
            r.done = 1'b1;
            if (cmd == OP_RESET || cmd == OP_ADDR || cmd == OP_GETACK) r.ack = ack_seen;
            if (cmd == OP_READ) r.rx_byte = shreg;
            else r.stuck = 1'b0;
            phase = SEQ_IDLE;
            ticks_left = '0;
         end
      end
      expected_ticks.push_back(r);
   endfunction

   function void check(tick_result_t got);
      tick_result_t exp_r;
      if (expected_ticks.size() == 0) begin
         $error("unexpected result transfer");
         errors++;
         return;
      end
      exp_r = expected_ticks.pop_front();
      if (got.drive_low !== exp_r.drive_low) begin
         $error("drive_low expected %0d actual %0d", exp_r.drive_low, got.drive_low);
         errors++;
      end
      if (got.busy !== exp_r.busy) begin
         $error("busy_res expected %0d actual %0d", exp_r.busy, got.busy);
         errors++;
      end
      if (got.done !== exp_r.done) begin
         $error("done_res expected %0d actual %0d", exp_r.done, got.done);
         errors++;
      end
      if (got.ack !== exp_r.ack) begin
         $error("ack expected %0d actual %0d", exp_r.ack, got.ack);
         errors++;
      end
      if (got.rx_byte !== exp_r.rx_byte) begin
         $error("rx_byte expected %0h actual %0h", exp_r.rx_byte, got.rx_byte);
         errors++;
      end
      if (got.stuck !== exp_r.stuck) begin
         $error("stuck_error expected %0d actual %0d", exp_r.stuck, got.stuck);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [3:0] csr_wdata;
   bit         gaps_on;
   int         low_burst;
   int         rsp_count;
   swbm_scoreboard sb;
   item_type   directed_q[$];

   swbm_req_if req();
   swbm_rsp_if rsp();

   single_wire_bus_master u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_tick(item_type it);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= it.op;
      req.tx_byte <= it.tx_byte;
      req.line_in <= it.line;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note(it);
   endtask

   // commands come from the per-phase list, busy ticks carry ignored codes
   function automatic item_type next_tick();
      item_type it;
      it.tx_byte = 8'($urandom_range(0, 255));
      it.op = 4'($urandom_range(0, 15));
      if (sb.phase == SEQ_IDLE) begin
         if (directed_q.size() > 0) it = directed_q.pop_front();
         else if (it.op < 4'd9) it.op = OP_TICK;
      end
      if (low_burst == 0 && sb.phase == SEQ_RD_POLL && $urandom_range(0, 5) == 0)
         low_burst = 105;
      if (low_burst > 0) begin
         it.line = 1'b0;
         low_burst--;
      end else begin
         it.line = ($urandom_range(0, 3) != 0);
      end
      return it;
   endfunction

   task automatic load_cmds(int p);
      case (p)
         0: begin
            directed_q.push_back('{OP_RESET, 8'h00, 1'b1});
            directed_q.push_back('{OP_START, 8'h00, 1'b1});
            directed_q.push_back('{OP_ADDR, 8'h96, 1'b1});
            directed_q.push_back('{OP_BYTE, 8'h3C, 1'b0});
            directed_q.push_back('{OP_READ, 8'h00, 1'b1});
            directed_q.push_back('{OP_GETACK, 8'h00, 1'b1});
            directed_q.push_back('{OP_SENDACK, 8'h00, 1'b1});
            directed_q.push_back('{OP_NACK, 8'h00, 1'b1});
            directed_q.push_back('{4'd9, 8'hA5, 1'b1});
            directed_q.push_back('{4'd15, 8'h5A, 1'b0});
         end
         1: begin
            directed_q.push_back('{OP_GETACK, 8'h00, 1'b1});
            directed_q.push_back('{OP_SENDACK, 8'h00, 1'b1});
         end
         2: begin
            directed_q.push_back('{OP_READ, 8'h00, 1'b1});
            directed_q.push_back('{OP_GETACK, 8'h00, 1'b1});
         end
         default: directed_q.push_back('{OP_GETACK, 8'h00, 1'b1});
      endcase
   endtask

   task automatic set_timing(logic spd, logic [3:0] rt);
      csr_we <= 1'b1;
      csr_index <= CSR_SPEED;
      csr_wdata <= {3'b000, spd};
      @(posedge clock);
      sb.write_reg(CSR_SPEED, {3'b000, spd});
      csr_index <= CSR_RETURN;
      csr_wdata <= rt;
      @(posedge clock);
      sb.write_reg(CSR_RETURN, rt);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check({rsp.drive_low, rsp.busy_res, rsp.done_res, rsp.ack, rsp.rx_byte,
                   rsp.stuck_error});
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int stall;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = gaps_on ? $urandom_range(0, 7) : 0;
         if (rsp_count == 400) stall = 60;
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         rsp_count++;
      end
   end

   initial begin
      logic       speeds [4];
      logic [3:0] returns [4];
      int         lengths [4];
      int         n;
      speeds = '{1'b1, 1'b0, 1'b1, 1'b1};
      returns = '{4'd2, 4'd0, 4'd0, 4'd15};
      lengths = '{20, 20, 20, 20};
      sb = new();
      gaps_on = 1'b1;
      low_burst = 0;
      rsp_count = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_SPEED;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.operation <= OP_TICK;
      req.tx_byte <= '0;
      req.line_in <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 4; p++) begin
         req.valid <= 1'b0;
         while (sb.expected_ticks.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         set_timing(speeds[p], returns[p]);
         load_cmds(p);
         n = 0;
         while (n < lengths[p] || sb.phase != SEQ_IDLE || directed_q.size() != 0) begin
            if (n % 100 == 99) gaps_on = !gaps_on;
            send_tick(next_tick());
            n++;
         end
      end
      req.valid <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
